// File: design/bam_pkg.sv
package bam_pkg;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_BLOCK_SIZE   = 2'd2,
		REG_RAMP_LENGTH  = 2'd3
	} reg_idx_t;

	localparam int IW_W = 11;
	localparam int IH_W = 13;
	localparam int BS_W = 5;
	localparam int RL_W = 7;

	localparam logic [IW_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
	localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
	localparam logic [BS_W-1:0] BLOCK_SIZE_RST   = 5'd4;
	localparam logic [RL_W-1:0] RAMP_LENGTH_RST  = 7'd64;
	localparam logic [RL_W-1:0] RAMP_LENGTH_MIN  = 7'd2;

	localparam int MAX_HEIGHT = 4096;
	localparam int HEIGHT_W   = 13;
	localparam int LINE_W     = 12;

	localparam int PIX_W      = 8;
	localparam int SUM_W      = 16;
	localparam int GRAY_ACC_W = 22;
	localparam int GRAY_SHIFT = 14;
	localparam logic [GRAY_ACC_W-1:0] W_BLUE     = 22'd1868;
	localparam logic [GRAY_ACC_W-1:0] W_GREEN    = 22'd9617;
	localparam logic [GRAY_ACC_W-1:0] W_RED      = 22'd4899;
	localparam logic [GRAY_ACC_W-1:0] GRAY_ROUND = 22'd8192;

	localparam int RAMP_CHARS = 64;
	localparam int IDX_W      = 6;
	localparam int CHAR_W     = 7;
	localparam int AVG_W      = 8;
	localparam logic [AVG_W-1:0] AVG_MAX = 8'd255;

	// first character sits in the top byte
	localparam logic [8*RAMP_CHARS-1:0] RAMP_STR =
		"$@B%8&WM#*oahkbdpqwmZ0BQLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!1I;;,";

	function automatic logic [CHAR_W-1:0] ramp_char(input logic [IDX_W-1:0] idx);
		logic [7:0] c;
		c = RAMP_STR[8*(RAMP_CHARS-1-int'(idx)) +: 8];
		return c[CHAR_W-1:0];
	endfunction

endpackage

// File: design/bam_ram.sv
module bam_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/bam_front.sv
module bam_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_TILE  = 16,
	localparam int CW   = $clog2(MAX_WIDTH),
	localparam int WW   = $clog2(MAX_WIDTH + 1),
	localparam int BW   = $clog2(MAX_TILE + 1),
	localparam int CNTW = 2 * BW,
	localparam int EW   = bam_pkg::SUM_W + CNTW + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [WW-1:0]                w,
	input  logic [bam_pkg::HEIGHT_W-1:0] h,
	input  logic [BW-1:0]                b,
	input  logic                         pixel_valid,
	output logic                         pixel_ready,
	input  logic [bam_pkg::PIX_W-1:0]    blue,
	input  logic [bam_pkg::PIX_W-1:0]    green,
	input  logic [bam_pkg::PIX_W-1:0]    red,
	input  logic                         start_of_frame,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [EW-1:0]                q_wdata
);
	import bam_pkg::*;

	localparam int TW = $clog2(MAX_TILE);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_ACC  = 2'b10
	} fstate_t;

	fstate_t state_q;

	logic [CW-1:0]     pcol_q, tcol_q;
	logic [LINE_W-1:0] pline_q;
	logic [TW-1:0]     cit_q, lit_q;

	logic [CW-1:0]       pc, tc;
	logic [LINE_W-1:0]   pl;
	logic [TW-1:0]       cit, lit;
	logic [WW-1:0]       pc_inc;
	logic [HEIGHT_W-1:0] pl_inc;
	logic [BW-1:0]       cit_inc, lit_inc;
	logic                row_end, last_line, col_last, line_last, emit;
	logic [CNTW-1:0]     cnt;
	logic [GRAY_ACC_W-1:0] gray_acc;
	logic                accept;

	logic [PIX_W-1:0] gray_s1;
	logic [CW-1:0]    slot_s1;
	logic             first_s1, emit_s1, row_s1, frame_s1;
	logic [CNTW-1:0]  cnt_s1;

	logic [SUM_W-1:0] ram_rdata, sum;

	// start of frame clears the counters before this pixel uses them
	assign pc  = start_of_frame ? '0 : pcol_q;
	assign tc  = start_of_frame ? '0 : tcol_q;
	assign pl  = start_of_frame ? '0 : pline_q;
	assign cit = start_of_frame ? '0 : cit_q;
	assign lit = start_of_frame ? '0 : lit_q;

	assign pc_inc    = WW'(pc) + WW'(1);
	assign pl_inc    = HEIGHT_W'(pl) + HEIGHT_W'(1);
	assign cit_inc   = BW'(cit) + BW'(1);
	assign lit_inc   = BW'(lit) + BW'(1);
	assign row_end   = pc_inc >= w;
	assign last_line = pl_inc >= h;
	assign col_last  = cit_inc >= b;
	assign line_last = lit_inc >= b;
	assign emit      = (col_last || row_end) && (line_last || last_line);
	assign cnt       = CNTW'(cit_inc) * CNTW'(lit_inc);

	assign gray_acc = GRAY_ACC_W'(blue) * W_BLUE + GRAY_ACC_W'(green) * W_GREEN
		+ GRAY_ACC_W'(red) * W_RED + GRAY_ROUND;

	assign pixel_ready = (state_q == F_IDLE) && !q_full;
	assign accept      = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pcol_q  <= '0;
			tcol_q  <= '0;
			pline_q <= '0;
			cit_q   <= '0;
			lit_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_ACC;
						if (row_end) begin
							pcol_q <= '0;
							cit_q  <= '0;
							tcol_q <= '0;
							if (last_line) begin
								pline_q <= '0;
								lit_q   <= '0;
							end else begin
								pline_q <= pl_inc[LINE_W-1:0];
								lit_q   <= line_last ? '0 : lit_inc[TW-1:0];
							end
						end else begin
							pcol_q  <= pc_inc[CW-1:0];
							pline_q <= pl;
							lit_q   <= lit;
							if (col_last) begin
								cit_q  <= '0;
								tcol_q <= tc + CW'(1);
							end else begin
								cit_q  <= cit_inc[TW-1:0];
								tcol_q <= tc;
							end
						end
					end
				end
				F_ACC: begin
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1  <= gray_acc[GRAY_SHIFT +: PIX_W];
			slot_s1  <= tc;
			first_s1 <= (cit == '0) && (lit == '0);
			emit_s1  <= emit;
			row_s1   <= row_end;
			frame_s1 <= row_end && last_line;
			cnt_s1   <= cnt;
		end
	end

	// column sums: read issued with the transaction, written back in the following cycle
	bam_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_WIDTH)
	) u_sums (
		.clk   (clk),
		.we    (state_q == F_ACC),
		.waddr (slot_s1),
		.wdata (sum),
		.raddr (tc),
		.rdata (ram_rdata)
	);

	assign sum     = first_s1 ? SUM_W'(gray_s1) : ram_rdata + SUM_W'(gray_s1);
	assign q_push  = (state_q == F_ACC) && emit_s1;
	assign q_wdata = {sum, cnt_s1, row_s1, frame_s1};

endmodule

// File: design/bam_fifo.sv
module bam_fifo #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = count_q == NW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: design/bam_back.sv
module bam_back #(
	parameter int MAX_TILE = 16,
	localparam int BW   = $clog2(MAX_TILE + 1),
	localparam int CNTW = 2 * BW,
	localparam int EW   = bam_pkg::SUM_W + CNTW + 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bam_pkg::IDX_W-1:0]  rlm1,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  logic [EW-1:0]              q_rdata,
	output logic                       char_valid,
	input  logic                       char_ready,
	output logic [bam_pkg::CHAR_W-1:0] char_code,
	output logic [bam_pkg::IDX_W-1:0]  ramp_index,
	output logic [bam_pkg::AVG_W-1:0]  tile_average,
	output logic                       end_of_row,
	output logic                       end_of_frame
);
	import bam_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);
	localparam int PROD_W = IDX_W + AVG_W;
	localparam int Q_W    = PROD_W + 1;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_MAP  = 3'b100
	} bstate_t;

	bstate_t state_q;

	logic [SUM_W-1:0]  quot_q;
	logic [CNTW-1:0]   rem_q, divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              row_q, frame_q;

	logic [CNTW:0]      trial, diff;
	logic               ge;
	logic [AVG_W-1:0]   avg;
	logic [PROD_W-1:0]  prod;
	logic [Q_W-1:0]     q255;
	logic [IDX_W-1:0]   idx;
	logic               load_out;

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, quot_q[SUM_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign ge    = trial >= {1'b0, divisor_q};

	assign avg  = (quot_q > SUM_W'(AVG_MAX)) ? AVG_MAX : quot_q[AVG_W-1:0];
	assign prod = PROD_W'(rlm1) * PROD_W'(avg);
	// exact floor(x/255) for x below 65535
	assign q255 = Q_W'(prod) + Q_W'(prod >> 8) + Q_W'(1);
	assign idx  = q255[8 +: IDX_W];

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign load_out = (state_q == B_MAP) && (!char_valid || char_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			step_q     <= '0;
			char_valid <= 1'b0;
		end else begin
			if (load_out) begin
				char_valid <= 1'b1;
			end else if (char_ready) begin
				char_valid <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						state_q <= B_DIV;
						step_q  <= '0;
					end
				end
				B_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= B_MAP;
					end
				end
				B_MAP: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			{quot_q, divisor_q, row_q, frame_q} <= q_rdata;
			rem_q <= '0;
		end else if (state_q == B_DIV) begin
			quot_q <= {quot_q[SUM_W-2:0], ge};
			rem_q  <= ge ? diff[CNTW-1:0] : trial[CNTW-1:0];
		end
		if (load_out) begin
			char_code    <= ramp_char(idx);
			ramp_index   <= idx;
			tile_average <= avg;
			end_of_row   <= row_q;
			end_of_frame <= frame_q;
		end
	end

endmodule

// File: design/block_average_ascii_mapper.sv
// Block-average ASCII mapper.
// Pixel channel (pixel_valid/pixel_ready): BGR pixels in raster order, with
// start_of_frame on the first pixel of a frame. Each pixel first reads the
// running column sum from the sum RAM, then adds the gray value and writes
// it back, and the input takes no new pixel until that write-back is done.
// Character channel (char_valid/char_ready): one character per finished
// tile, with its ramp index, average and row/frame end flags. Completed
// tiles wait in a 2-entry queue; the back end divides each tile sum by its
// pixel count with a radix-2 divider, maps the quotient to a ramp index and
// presents the character from an output register, and pops no new tile
// until that character is loaded into the output register.
// A stalled receiver holds the output register; the queue absorbs two more
// tiles, then pixel_ready drops until the back end frees a slot.
// Reset clears the counters, the queue and the output valid, and loads the
// register defaults (640x480, 4-pixel tiles, 64 ramp characters). The sum
// RAM needs no clearing: the first pixel of each tile overwrites its entry.
// APB registers: 0x0 image_width, 0x4 image_height, 0x8 block_size,
// 0xC ramp_length; write them only while no transaction is in flight.
module block_average_ascii_mapper #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_TILE   = 16,
	parameter int RAMP_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       pixel_valid,
	output logic                       pixel_ready,
	input  logic [bam_pkg::PIX_W-1:0]  blue,
	input  logic [bam_pkg::PIX_W-1:0]  green,
	input  logic [bam_pkg::PIX_W-1:0]  red,
	input  logic                       start_of_frame,
	output logic                       char_valid,
	input  logic                       char_ready,
	output logic [bam_pkg::CHAR_W-1:0] char_code,
	output logic [bam_pkg::IDX_W-1:0]  ramp_index,
	output logic [bam_pkg::AVG_W-1:0]  tile_average,
	output logic                       end_of_row,
	output logic                       end_of_frame
);
	import bam_pkg::*;

	localparam int WW       = $clog2(MAX_WIDTH + 1);
	localparam int BW       = $clog2(MAX_TILE + 1);
	localparam int CNTW     = 2 * BW;
	localparam int EW       = SUM_W + CNTW + 2;
	localparam int RMAX     = (RAMP_DEPTH < RAMP_CHARS) ? RAMP_DEPTH : RAMP_CHARS;
	localparam int Q_DEPTH  = 2;

	logic [IW_W-1:0] image_width_q;
	logic [IH_W-1:0] image_height_q;
	logic [BS_W-1:0] block_size_q;
	logic [RL_W-1:0] ramp_length_q;

	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic [WW-1:0]       w_c;
	logic [HEIGHT_W-1:0] h_c;
	logic [BW-1:0]       b_c;
	logic [RL_W-1:0]     rl_c;
	logic [IDX_W-1:0]    rlm1;

	logic          q_push, q_pop, q_full, q_empty;
	logic [EW-1:0] q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			block_size_q   <= BLOCK_SIZE_RST;
			ramp_length_q  <= RAMP_LENGTH_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[IW_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[IH_W-1:0];
				REG_BLOCK_SIZE:   block_size_q   <= pwdata[BS_W-1:0];
				REG_RAMP_LENGTH:  ramp_length_q  <= pwdata[RL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
			REG_BLOCK_SIZE:   prdata = 32'(block_size_q);
			REG_RAMP_LENGTH:  prdata = 32'(ramp_length_q);
			default:          prdata = '0;
		endcase
	end

	// clamp registers into the supported ranges
	always_comb begin
		if (image_width_q == '0) begin
			w_c = WW'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(image_width_q);
		end

		if (image_height_q == '0) begin
			h_c = HEIGHT_W'(1);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			h_c = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			h_c = image_height_q;
		end

		if (block_size_q == '0) begin
			b_c = BW'(1);
		end else if (32'(block_size_q) > MAX_TILE) begin
			b_c = BW'(MAX_TILE);
		end else begin
			b_c = BW'(block_size_q);
		end

		if (ramp_length_q < RAMP_LENGTH_MIN) begin
			rl_c = RAMP_LENGTH_MIN;
		end else if (32'(ramp_length_q) > RMAX) begin
			rl_c = RL_W'(RMAX);
		end else begin
			rl_c = ramp_length_q;
		end
	end

	assign rlm1 = IDX_W'(rl_c - RL_W'(1));

	bam_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_TILE  (MAX_TILE)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.w              (w_c),
		.h              (h_c),
		.b              (b_c),
		.pixel_valid    (pixel_valid),
		.pixel_ready    (pixel_ready),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.start_of_frame (start_of_frame),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_wdata        (q_wdata)
	);

	bam_fifo #(
		.WIDTH (EW),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	bam_back #(
		.MAX_TILE (MAX_TILE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rlm1         (rlm1),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_rdata      (q_rdata),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.ramp_index   (ramp_index),
		.tile_average (tile_average),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

endmodule

// File: design/bam_checker.sv
module bam_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pixel_valid,
	input logic                       pixel_ready,
	input logic                       char_valid,
	input logic                       char_ready,
	input logic [bam_pkg::CHAR_W-1:0] char_code,
	input logic [bam_pkg::IDX_W-1:0]  ramp_index,
	input logic [bam_pkg::AVG_W-1:0]  tile_average,
	input logic                       end_of_row,
	input logic                       end_of_frame
);

	// each pixel occupies the sum RAM for a read and then a write-back
	a_pixel_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> !pixel_ready)
		else $error("pixel accepted on consecutive cycles");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && end_of_frame |-> end_of_row)
		else $error("frame end without row end");

	a_dark_index: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && tile_average == '0 |-> ramp_index == '0)
		else $error("zero average mapped to nonzero ramp index");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=> char_valid && $stable(char_code)
			&& $stable(tile_average) && $stable(ramp_index))
		else $error("stalled character transaction changed");

endmodule

bind block_average_ascii_mapper bam_checker u_bam_checker (.*);

// File: dv/block_average_ascii_mapper_tb.sv
`timescale 1ns / 1ps

module block_average_ascii_mapper_tb;
	import bam_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int MAX_T         = 16;
	localparam int RAMP_D        = 64;
	localparam int RAMP_USED     = (RAMP_D < RAMP_CHARS) ? RAMP_D : RAMP_CHARS;
	localparam int ITEM_TARGET   = 650;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 600000;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
		logic             sof;
	} pixel_t;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic [IDX_W-1:0]  index;
		logic [AVG_W-1:0]  average;
		logic              row_end;
		logic              frame_end;
	} glyph_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [3:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              pixel_valid = 1'b0;
	logic              pixel_ready;
	logic [PIX_W-1:0]  blue = '0;
	logic [PIX_W-1:0]  green = '0;
	logic [PIX_W-1:0]  red = '0;
	logic              start_of_frame = 1'b0;
	logic              char_valid;
	logic              char_ready = 1'b0;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  ramp_index;
	logic [AVG_W-1:0]  tile_average;
	logic              end_of_row;
	logic              end_of_frame;

	block_average_ascii_mapper #(
		.MAX_WIDTH (MAX_W),
		.MAX_TILE  (MAX_T),
		.RAMP_DEPTH(RAMP_D)
	) DUT (.*);

	// shadow registers and counters of the mapper
	logic [IW_W-1:0] width_reg  = IMAGE_WIDTH_RST;
	logic [IH_W-1:0] height_reg = IMAGE_HEIGHT_RST;
	logic [BS_W-1:0] tile_reg   = BLOCK_SIZE_RST;
	logic [RL_W-1:0] ramp_reg   = RAMP_LENGTH_RST;
	logic [SUM_W-1:0] tile_acc [MAX_W];
	int unsigned col_pos, row_pos, sub_col, sub_row, tile_idx;
	string glyph_ramp =
		"$@B%8&WM#*oahkbdpqwmZ0BQLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!1I;;,";

	pixel_t pending_pixels[$];
	glyph_t glyphs_due[$];
	pixel_t cur_pixel;
	glyph_t due_glyph;
	glyph_t seen_glyph;
	int sender_idle_pct = 13;
	int receiver_idle_pct = 71;
	int error_count = 0;
	int queued_items = 0;
	int unsigned cycle_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic void render_pixel(input pixel_t px);
		int unsigned w, h, b, rl, gray, slot, sum, cnt, avg, idx;
		bit row_end, frame_end, col_end, line_end;
		glyph_t g;
		byte c;
		w  = clip(width_reg, 1, MAX_W);
		h  = clip(height_reg, 1, MAX_HEIGHT);
		b  = clip(tile_reg, 1, MAX_T);
		rl = clip(ramp_reg, 2, RAMP_USED);
		if (px.sof) begin
			col_pos = 0;
			row_pos = 0;
			sub_col = 0;
			sub_row = 0;
			tile_idx = 0;
		end
		gray = (1868 * px.blue + 9617 * px.green + 4899 * px.red + 8192) >> 14;
		slot = (tile_idx < MAX_W) ? tile_idx : MAX_W - 1;
		if (sub_row == 0 && sub_col == 0)
			sum = gray;
		else
			sum = (tile_acc[slot] + gray) & 32'hFFFF;
		tile_acc[slot] = sum[SUM_W-1:0];

		row_end   = col_pos + 1 >= w;
		frame_end = row_end && row_pos + 1 >= h;
		col_end   = sub_col + 1 >= b || row_end;
		line_end  = sub_row + 1 >= b || row_pos + 1 >= h;

		if (col_end && line_end) begin
			cnt = (sub_col + 1) * (sub_row + 1);
			avg = sum / cnt;
			if (avg > 255)
				avg = 255;
			idx = (rl - 1) * avg / 255;
			if (idx >= RAMP_CHARS)
				idx = RAMP_CHARS - 1;
			c = glyph_ramp[idx];
			g.code      = c[CHAR_W-1:0];
			g.index     = idx[IDX_W-1:0];
			g.average   = avg[AVG_W-1:0];
			g.row_end   = row_end;
			g.frame_end = frame_end;
			glyphs_due.push_back(g);
		end

		if (row_end) begin
			col_pos = 0;
			sub_col = 0;
			tile_idx = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				sub_row = 0;
			end else begin
				row_pos++;
				sub_row = (sub_row + 1 >= b) ? 0 : sub_row + 1;
			end
		end else begin
			col_pos++;
			if (sub_col + 1 >= b) begin
				sub_col = 0;
				tile_idx++;
			end else begin
				sub_col++;
			end
		end
	endfunction

	task automatic flag_error(input string what);
		error_count++;
		if (error_count <= 10)
			$display("ERROR @%0d: %s", cycle_count, what);
	endtask

	// pixel driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && pixel_ready)
				render_pixel(cur_pixel);
			if (!pixel_valid || pixel_ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					cur_pixel = pending_pixels.pop_front();
					pixel_valid    <= 1'b1;
					blue           <= cur_pixel.blue;
					green          <= cur_pixel.green;
					red            <= cur_pixel.red;
					start_of_frame <= cur_pixel.sof;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// character monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && char_ready) begin
				seen_glyph = '{char_code, ramp_index, tile_average, end_of_row, end_of_frame};
				if (glyphs_due.size() == 0) begin
					flag_error($sformatf("unexpected char code=%0d idx=%0d avg=%0d eor=%0b eof=%0b",
						char_code, ramp_index, tile_average, end_of_row, end_of_frame));
				end else begin
					due_glyph = glyphs_due.pop_front();
					if (seen_glyph !== due_glyph)
						flag_error($sformatf({"char mismatch: exp code=%0d idx=%0d avg=%0d ",
							"eor=%0b eof=%0b, got code=%0d idx=%0d avg=%0d eor=%0b eof=%0b"},
							due_glyph.code, due_glyph.index, due_glyph.average,
							due_glyph.row_end, due_glyph.frame_end, char_code, ramp_index,
							tile_average, end_of_row, end_of_frame));
				end
			end
			char_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  width_reg  = data[IW_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = data[IH_W-1:0];
			REG_BLOCK_SIZE:   tile_reg   = data[BS_W-1:0];
			REG_RAMP_LENGTH:  ramp_reg   = data[RL_W-1:0];
		endcase
	endtask

	task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned b,
			input int unsigned r);
		apb_write(REG_IMAGE_WIDTH, w);
		apb_write(REG_IMAGE_HEIGHT, h);
		apb_write(REG_BLOCK_SIZE, b);
		apb_write(REG_RAMP_LENGTH, r);
	endtask

	// wait for every queued pixel and expected char, then let the tail settle
	task automatic drain_all();
		do @(negedge clk);
		while (pending_pixels.size() != 0 || pixel_valid || glyphs_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_pixel(input int b, input int g, input int r, input bit sof);
		pending_pixels.push_back('{b[7:0], g[7:0], r[7:0], sof});
		queued_items++;
	endtask

	// level < 0: uniform noise, else all components near the level
	task automatic push_random_pixel(input bit sof, input int level);
		if (level < 0)
			push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), sof);
		else
			push_pixel(level ^ $urandom_range(15), level ^ $urandom_range(15),
				level ^ $urandom_range(15), sof);
	endtask

	initial begin
		int unsigned w, h, b, r, frame_len, frames, phase_no;
		int level;
		bit sof;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// 3x3 image, 2x2 tiles: full, right-clipped, bottom-clipped and corner tiles
		set_geometry(3, 3, 2, 64);
		push_pixel(0, 0, 0, 1);
		push_pixel(255, 255, 255, 0);
		push_pixel(255, 0, 0, 0);
		push_pixel(0, 255, 0, 0);
		push_pixel(0, 0, 255, 0);
		push_pixel(255, 255, 255, 0);
		push_pixel(128, 64, 32, 0);
		push_pixel(1, 2, 3, 0);
		push_pixel(255, 255, 255, 0);
		// next frame with no start mark, then a start mark in the middle of it
		push_pixel(200, 10, 90, 0);
		push_pixel(17, 240, 33, 0);
		push_pixel(99, 99, 99, 0);
		push_pixel(255, 255, 255, 0);
		push_pixel(0, 0, 0, 0);
		push_pixel(60, 180, 250, 0);
		push_pixel(7, 7, 7, 1);
		push_pixel(250, 5, 128, 0);
		push_pixel(33, 66, 99, 0);
		drain_all();

		// tile shrinks from 4 to 1 halfway down a tile row: average saturates
		set_geometry(2, 4, 4, 2);
		push_pixel(255, 255, 255, 1);
		repeat (3) push_pixel(255, 255, 255, 0);
		drain_all();
		apb_write(REG_BLOCK_SIZE, 1);
		repeat (4) push_pixel(255, 255, 255, 0);

		phase_no = 0;
		while (queued_items < ITEM_TARGET) begin
			drain_all();
			if (queued_items < 26 + 218) begin
				sender_idle_pct = 13;
				receiver_idle_pct = 71;
			end else if (queued_items < 26 + 436) begin
				sender_idle_pct = 71;
				receiver_idle_pct = 13;
			end else begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			case (phase_no)
				0: set_geometry(0, 0, 0, 0);
				1: set_geometry(2047, 1, 31, 127);
				2: set_geometry(7, 8191, 16, 1);
				3: set_geometry(1, 4096, 1, 64);
				default: begin
					case ($urandom_range(5))
						0, 1, 2: w = $urandom_range(1, 8);
						3, 4:    w = $urandom_range(9, 40);
						default: w = $urandom_range(2047);
					endcase
					case ($urandom_range(5))
						0, 1, 2, 3: h = $urandom_range(1, 8);
						4:          h = $urandom_range(9, 32);
						default:    h = $urandom_range(8191);
					endcase
					case ($urandom_range(5))
						0, 1, 2, 3: b = $urandom_range(1, 6);
						4:          b = $urandom_range(7, 16);
						default:    b = $urandom_range(31);
					endcase
					r = $urandom_range(1) ? $urandom_range(127) : $urandom_range(2, 64);
					set_geometry(w, h, b, r);
				end
			endcase
			phase_no++;

			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				frame_len = clip(width_reg, 1, MAX_W) * clip(height_reg, 1, MAX_HEIGHT);
				if (frame_len > 160)
					frame_len = $urandom_range(40, 140);
				level = $urandom_range(1) ? -1 : int'($urandom_range(255));
				for (int i = 0; i < frame_len && queued_items < ITEM_TARGET; i++) begin
					// first frame after a register write always starts clean
					if (i == 0)
						sof = (f == 0) || ($urandom_range(5) != 0);
					else
						sof = ($urandom_range(39) == 0);
					push_random_pixel(sof, level);
				end
				if ($urandom_range(3) == 0)
					drain_all();
			end
		end

		drain_all();
		if (error_count == 0 && glyphs_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
design/bam_pkg.sv
design/bam_ram.sv
design/bam_front.sv
design/bam_fifo.sv
design/bam_back.sv
design/block_average_ascii_mapper.sv
design/bam_checker.sv
dv/block_average_ascii_mapper_tb.sv
